// ===== hw/rtl/waterfall_line_store_raster_macros.svh =====
// Assertion macros shared by the waterfall line store RTL.
`ifndef WATERFALL_LINE_STORE_RASTER_MACROS_SVH
`define WATERFALL_LINE_STORE_RASTER_MACROS_SVH
`ifndef ASSERT_OFF
`define WLS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WLS_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WLS_ASSERT(label, clk, rst_n, prop, msg)
`define WLS_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/wls_pkg.sv =====
// Shared types and constants for the waterfall line store.
package wls_pkg;

    localparam int FUNC_W      = 2;
    localparam int CELL_REQ_W  = 8;
    localparam int INTENSITY_W = 8;
    localparam int PIX_W       = 8;
    localparam int COLOR_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NEWLINE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FLOW_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_A   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_B   = 2'd2;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 16'hFFFF;

    typedef struct packed {
        logic load_wr;
        logic load_rd;
        logic head_adv;
        logic clr_start;
        logic clr_step;
        logic mod_step;
        logic line_calc;
        logic addr_calc;
        logic wr_en;
        logic mul;
        logic out_load;
    } wls_cmd_t;

    typedef struct packed {
        logic mode_chg;
        logic clr_last;
        logic mod_last;
        logic out_free;
    } wls_sts_t;

endpackage

// ===== hw/rtl/wls_if.sv =====
// Request and response channel interfaces for the waterfall line store.
interface wls_req_if import wls_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FUNC_W-1:0]      func;
    logic                   channel;
    logic [CELL_REQ_W-1:0]  cell_req;
    logic [INTENSITY_W-1:0] intensity;
    logic [PIX_W-1:0]       pix_x;
    logic [PIX_W-1:0]       pix_y;

    modport source (output valid, func, channel, cell_req, intensity, pix_x, pix_y,
                    input ready);
    modport sink (input valid, func, channel, cell_req, intensity, pix_x, pix_y,
                  output ready);
endinterface

interface wls_rsp_if import wls_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;

    modport source (output valid, pixel_color, input ready);
    modport sink (input valid, pixel_color, output ready);
endinterface

// ===== hw/rtl/wls_ctrl.sv =====
// Controller state machine sequencing clear, new line, write and pixel read requests.
`include "waterfall_line_store_raster_macros.svh"

module wls_ctrl import wls_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [FUNC_W-1:0] req_func,
    output logic              req_ready,
    input  wls_sts_t          sts,
    output wls_cmd_t          cmd
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_WADDR = 4'd2;
    localparam logic [3:0] ST_WRITE = 4'd3;
    localparam logic [3:0] ST_MOD   = 4'd4;
    localparam logic [3:0] ST_LINE  = 4'd5;
    localparam logic [3:0] ST_RADDR = 4'd6;
    localparam logic [3:0] ST_READ  = 4'd7;
    localparam logic [3:0] ST_MUL   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_func)
                        FUNC_CLEAR:
                        begin
                            cmd.clr_start = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        FUNC_NEWLINE:
                        begin
                            cmd.head_adv = 1'b1;
                        end
                        FUNC_WRITE:
                        begin
                            cmd.load_wr = 1'b1;
                            state_next  = ST_WADDR;
                        end
                        FUNC_READ:
                        begin
                            cmd.load_rd = 1'b1;
                            state_next  = ST_MOD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WADDR:
            begin
                cmd.addr_calc = 1'b1;
                state_next    = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.wr_en  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                begin
                    state_next = ST_LINE;
                end
            end
            ST_LINE:
            begin
                cmd.line_calc = 1'b1;
                state_next    = ST_RADDR;
            end
            ST_RADDR:
            begin
                cmd.addr_calc = 1'b1;
                state_next    = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        // restart the sweep on a mode change
        if (sts.mode_chg)
        begin
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `WLS_ASSERT(a_one_start, clk, rst_n, $onehot0({cmd.load_wr, cmd.load_rd, cmd.head_adv, cmd.clr_start}), "more than one request start at once")
    `WLS_ASSERT(a_mode_clear, clk, rst_n, sts.mode_chg |=> (state_reg == ST_CLEAR), "mode change did not start a clear sweep")

endmodule

// ===== hw/rtl/wls_dp.sv =====
// Datapath: line stores, head, remainder unit, address, ramp and output register.
`include "waterfall_line_store_raster_macros.svh"

module wls_dp import wls_pkg::*; #(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 240,
    parameter int CELLS_UP      = 120,
    parameter int LINES_UP      = 240,
    parameter int CELLS_OUT     = 240,
    parameter int LINES_OUT     = 120
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wls_cmd_t               cmd,
    output wls_sts_t               sts,
    input  logic                   req_channel,
    input  logic [CELL_REQ_W-1:0]  req_cell_req,
    input  logic [INTENSITY_W-1:0] req_intensity,
    input  logic [PIX_W-1:0]       req_pix_x,
    input  logic [PIX_W-1:0]       req_pix_y,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic [COLOR_W-1:0]     rsp_pixel_color,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int HALF      = SCREEN_WIDTH / 2;
    localparam int MAX_CELLS = (CELLS_UP > CELLS_OUT) ? CELLS_UP : CELLS_OUT;
    localparam int MAX_LINES = (LINES_UP > LINES_OUT) ? LINES_UP : LINES_OUT;
    localparam int PROD_UP   = CELLS_UP * LINES_UP;
    localparam int PROD_OUT  = CELLS_OUT * LINES_OUT;
    localparam int CH_SIZE   = (PROD_UP > PROD_OUT) ? PROD_UP : PROD_OUT;
    localparam int SCR_MAX   = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int CO_MAX0   = (SCR_MAX > MAX_CELLS) ? SCR_MAX : MAX_CELLS;
    localparam int PIX_SPAN  = 1 << PIX_W;
    localparam int CO_MAX    = (CO_MAX0 > PIX_SPAN) ? CO_MAX0 : PIX_SPAN;
    localparam int CO_W      = $clog2(CO_MAX + 1);
    localparam int LN_W      = $clog2(MAX_LINES + 1);
    localparam int ADDR_W    = (CH_SIZE > 1) ? $clog2(CH_SIZE) : 1;
    localparam int STEP_W    = $clog2(CO_W);
    localparam int SUM_W     = LN_W + CO_W + 1;

    localparam logic [CO_W-1:0]   SW_C        = CO_W'(SCREEN_WIDTH);
    localparam logic [CO_W-1:0]   SH_C        = CO_W'(SCREEN_HEIGHT);
    localparam logic [CO_W-1:0]   SW_M1_C     = CO_W'(SCREEN_WIDTH - 1);
    localparam logic [CO_W-1:0]   SH_M1_C     = CO_W'(SCREEN_HEIGHT - 1);
    localparam logic [CO_W-1:0]   HALF_C      = CO_W'(HALF);
    localparam logic [CO_W-1:0]   HALF_M1_C   = CO_W'(HALF - 1);
    localparam logic [CO_W-1:0]   CELLS_UP_C  = CO_W'(CELLS_UP);
    localparam logic [CO_W-1:0]   CELLS_OUT_C = CO_W'(CELLS_OUT);
    localparam logic [LN_W-1:0]   LINES_UP_C  = LN_W'(LINES_UP);
    localparam logic [LN_W-1:0]   LINES_OUT_C = LN_W'(LINES_OUT);
    localparam logic [ADDR_W-1:0] CLR_LAST_C  = ADDR_W'(CH_SIZE - 1);
    localparam logic [STEP_W-1:0] STEP_LAST_C = STEP_W'(CO_W - 1);

    function automatic logic [5:0] div255(input logic [13:0] p);
        logic [15:0] s;
        s = {2'b00, p} + {10'b0, p[13:8]} + 16'd1;
        return s[13:8];
    endfunction

    logic [INTENSITY_W-1:0] mem_a [CH_SIZE];
    logic [INTENSITY_W-1:0] mem_b [CH_SIZE];

    logic                   flow_mode_reg;
    logic [COLOR_W-1:0]     color_a_reg;
    logic [COLOR_W-1:0]     color_b_reg;
    logic [LN_W-1:0]        head_reg;
    logic [ADDR_W-1:0]      clr_cnt_reg;
    logic                   out_valid_reg;
    logic [COLOR_W-1:0]     out_color_reg;

    logic                   ch_reg;
    logic [CO_W-1:0]        cell_reg;
    logic                   ok_reg;
    logic [LN_W-1:0]        line_reg;
    logic [INTENSITY_W-1:0] int_reg;
    logic [CO_W-1:0]        age_reg;
    logic [LN_W-1:0]        rem_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [INTENSITY_W-1:0] rd_a_reg;
    logic [INTENSITY_W-1:0] rd_b_reg;
    logic [12:0]            pr_reg;
    logic [13:0]            pg_reg;
    logic [12:0]            pb_reg;

    logic [CO_W-1:0]        cells_c;
    logic [LN_W-1:0]        lines_c;
    logic [LN_W:0]          lines_x;
    logic                   mode_chg;
    logic [CO_W-1:0]        xw;
    logic [CO_W-1:0]        yw;
    logic                   on_scr;
    logic                   chx;
    logic [CO_W-1:0]        xm;
    logic [CO_W-1:0]        age_map;
    logic [CO_W-1:0]        cell_map;
    logic [CO_W-1:0]        cell_wr;
    logic [LN_W:0]          r2;
    logic [LN_W:0]          rem_next;
    logic [LN_W:0]          t_sum;
    logic [LN_W:0]          line_next;
    logic [LN_W:0]          head_inc;
    logic [LN_W-1:0]        head_next;
    logic [LN_W+CO_W-1:0]   prod;
    logic [SUM_W-1:0]       addr_sum;
    logic [INTENSITY_W-1:0] v_sel;
    logic [COLOR_W-1:0]     col_sel;
    logic [5:0]             r_q;
    logic [5:0]             g_q;
    logic [5:0]             b_q;
    logic                   we_a;
    logic                   we_b;
    logic [ADDR_W-1:0]      waddr;
    logic [INTENSITY_W-1:0] wdata;

    assign cells_c  = flow_mode_reg ? CELLS_OUT_C : CELLS_UP_C;
    assign lines_c  = flow_mode_reg ? LINES_OUT_C : LINES_UP_C;
    assign lines_x  = {1'b0, lines_c};
    assign mode_chg = cfg_we && (cfg_index == REG_FLOW_MODE) && (cfg_data[0] != flow_mode_reg);

    // map a screen position to channel, age and cell
    assign xw       = {{(CO_W - PIX_W){1'b0}}, req_pix_x};
    assign yw       = {{(CO_W - PIX_W){1'b0}}, req_pix_y};
    assign on_scr   = (xw < SW_C) && (yw < SH_C);
    assign chx      = !(xw < HALF_C);
    assign xm       = chx ? (SW_M1_C - xw) : xw;
    assign age_map  = flow_mode_reg ? ((xm < HALF_C) ? (HALF_M1_C - xm) : '0)
                                    : (SH_M1_C - yw);
    assign cell_map = flow_mode_reg ? (SH_M1_C - yw)
                                    : (chx ? (xw - HALF_C) : (HALF_M1_C - xw));
    assign cell_wr  = {{(CO_W - CELL_REQ_W){1'b0}}, req_cell_req};

    // one restoring remainder step of age by the line count
    assign r2       = {rem_reg, age_reg[CO_W-1]};
    assign rem_next = (r2 >= lines_x) ? (r2 - lines_x) : r2;

    assign t_sum     = {1'b0, head_reg} + lines_x - {1'b0, rem_reg};
    assign line_next = (t_sum >= lines_x) ? (t_sum - lines_x) : t_sum;

    assign head_inc  = {1'b0, head_reg} + {{LN_W{1'b0}}, 1'b1};
    assign head_next = (head_inc == lines_x) ? '0 : head_inc[LN_W-1:0];

    assign prod     = {{CO_W{1'b0}}, line_reg} * {{LN_W{1'b0}}, cells_c};
    assign addr_sum = {1'b0, prod} + {{(LN_W + 1){1'b0}}, cell_reg};

    assign v_sel   = ok_reg ? (ch_reg ? rd_b_reg : rd_a_reg) : '0;
    assign col_sel = ch_reg ? color_b_reg : color_a_reg;

    assign r_q = div255({1'b0, pr_reg});
    assign g_q = div255(pg_reg);
    assign b_q = div255({1'b0, pb_reg});

    assign we_a  = cmd.clr_step || (cmd.wr_en && ok_reg && !ch_reg);
    assign we_b  = cmd.clr_step || (cmd.wr_en && ok_reg && ch_reg);
    assign waddr = cmd.clr_step ? clr_cnt_reg : addr_reg;
    assign wdata = cmd.clr_step ? '0 : int_reg;

    assign sts.mode_chg = mode_chg;
    assign sts.clr_last = (clr_cnt_reg == CLR_LAST_C);
    assign sts.mod_last = (step_reg == STEP_LAST_C);
    assign sts.out_free = !out_valid_reg || rsp_ready;

    assign rsp_valid       = out_valid_reg;
    assign rsp_pixel_color = out_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_mode_reg <= 1'b0;
            color_a_reg   <= COLOR_RESET;
            color_b_reg   <= COLOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FLOW_MODE: flow_mode_reg <= cfg_data[0];
                REG_COLOR_A:   color_a_reg   <= cfg_data;
                REG_COLOR_B:   color_b_reg   <= cfg_data;
                default:       flow_mode_reg <= flow_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            clr_cnt_reg <= '0;
        end
        else if (mode_chg || cmd.clr_start)
        begin
            head_reg    <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.head_adv)
            begin
                head_reg <= head_next;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + {{(ADDR_W - 1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.load_rd)
        begin
            step_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            step_reg <= step_reg + {{(STEP_W - 1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            ch_reg   <= req_channel;
            cell_reg <= cell_wr;
            ok_reg   <= (cell_wr < cells_c);
            line_reg <= head_reg;
            int_reg  <= req_intensity;
        end
        if (cmd.load_rd)
        begin
            ch_reg   <= chx;
            cell_reg <= cell_map;
            ok_reg   <= on_scr && (cell_map < cells_c);
            age_reg  <= age_map;
            rem_reg  <= '0;
        end
        if (cmd.mod_step)
        begin
            rem_reg <= rem_next[LN_W-1:0];
            age_reg <= {age_reg[CO_W-2:0], 1'b0};
        end
        if (cmd.line_calc)
        begin
            line_reg <= line_next[LN_W-1:0];
        end
        if (cmd.addr_calc)
        begin
            addr_reg <= addr_sum[ADDR_W-1:0];
        end
        if (cmd.mul)
        begin
            pr_reg <= {8'b0, col_sel[15:11]} * {5'b0, v_sel};
            pg_reg <= {8'b0, col_sel[10:5]} * {6'b0, v_sel};
            pb_reg <= {8'b0, col_sel[4:0]} * {5'b0, v_sel};
        end
        if (cmd.out_load)
        begin
            out_color_reg <= {r_q[4:0], g_q, b_q[4:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[waddr] <= wdata;
        end
        rd_a_reg <= mem_a[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            mem_b[waddr] <= wdata;
        end
        rd_b_reg <= mem_b[addr_reg];
    end

    `WLS_ASSERT_NORST(a_head_range, clk, head_reg < lines_c, "head line beyond line count")
    `WLS_ASSERT(a_rem_range, clk, rst_n, cmd.line_calc |-> (rem_reg < lines_c), "age remainder not below line count")
    `WLS_ASSERT(a_out_slot, clk, rst_n, cmd.out_load |-> (!out_valid_reg || rsp_ready), "result loaded over a pending one")

endmodule

// ===== hw/rtl/waterfall_line_store_raster.sv =====
// Top level of the two-channel waterfall line store with raster pixel reader.
//
// Requests arrive on req (valid/ready): clear, new line, cell write or pixel read.
// Only a pixel read returns a result, an RGB565 color on rsp (valid/ready).
// Configuration uses cfg_we/cfg_index/cfg_data: flow mode, color A, color B;
// changing the flow mode clears both stores and the head line.
// A new line completes on acceptance; a cell write computes its address, then writes.
// A pixel read runs the bit-serial remainder of the line age by the line count,
// then computes the line and address, reads, multiplies and loads the output.
// A clear request sweeps both stores one entry a cycle over 28800 entries at the
// default sizes (the larger of the two cell-by-line products).
// After reset the same sweep runs; req.ready stays low until it ends.
// A finished pixel sits in the output register; while rsp.ready is low the
// block still takes new line and write requests, and a following pixel read
// waits in its last step until the register frees.
module waterfall_line_store_raster import wls_pkg::*; #(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 240,
    parameter int CELLS_UP      = 120,
    parameter int LINES_UP      = 240,
    parameter int CELLS_OUT     = 240,
    parameter int LINES_OUT     = 120
) (
    input  logic                  clk,
    input  logic                  rst_n,
    wls_req_if.sink               req,
    wls_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    wls_cmd_t cmd;
    wls_sts_t sts;
    logic     ready;

    assign req.ready = ready;

    wls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    wls_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .CELLS_UP      (CELLS_UP),
        .LINES_UP      (LINES_UP),
        .CELLS_OUT     (CELLS_OUT),
        .LINES_OUT     (LINES_OUT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .req_channel     (req.channel),
        .req_cell_req    (req.cell_req),
        .req_intensity   (req.intensity),
        .req_pix_x       (req.pix_x),
        .req_pix_y       (req.pix_y),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_pixel_color (rsp.pixel_color),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

endmodule
